// ===== rtl/gpioirq_pkg.sv =====
// Shared types and constants for the GPIO controller with event interrupts.
package gpioirq_pkg;

    // Default build configuration.
    localparam int PinCountDefault      = 16;
    localparam int HasOutputLevelDefault = 1;

    // Operation carried by an input beat.
    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_SAMPLE = 2'd2
    } op_t;

    // Word register selected by address bits [3:1] of the byte bank.
    typedef enum logic [2:0] {
        REG_DIRECTION = 3'd0,
        REG_PIN_LEVEL = 3'd1,
        REG_STATUS    = 3'd2,
        REG_EV_MODE   = 3'd3,
        REG_EV_POL    = 3'd4,
        REG_IRQ_EN    = 3'd5,
        REG_NMI_EN    = 3'd6,
        REG_OUT_LEVEL = 3'd7
    } reg_idx_t;

    // One input item as held in the input register.
    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  address;
        logic [7:0]  write_data;
        logic [15:0] pin_levels;
    } cmd_t;

    // One result item as produced by the register bank.
    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] pin_drive;
        logic [15:0] pin_drive_enable;
        logic        irq_out;
        logic        nmi_out;
    } result_t;

endpackage

// ===== rtl/gpioirq_regs.sv =====
// Register bank, event latching and interrupt outputs of the GPIO controller.
module gpioirq_regs #(
    parameter int PIN_COUNT            = gpioirq_pkg::PinCountDefault,
    parameter int HAS_OUTPUT_LEVEL_REG = gpioirq_pkg::HasOutputLevelDefault
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 apply,
    input  gpioirq_pkg::cmd_t    cmd,
    output gpioirq_pkg::result_t result
);

    localparam logic [15:0] PinMask =
        (PIN_COUNT >= 16) ? 16'hFFFF : 16'((32'd1 << PIN_COUNT) - 32'd1);

    logic [15:0] dir_reg, dir_next;
    logic [15:0] outlvl_reg, outlvl_next;
    logic [15:0] status_reg, status_next;
    logic [15:0] mode_reg, mode_next;
    logic [15:0] pol_reg, pol_next;
    logic [15:0] irqen_reg, irqen_next;
    logic [15:0] nmien_reg, nmien_next;
    logic [15:0] prev_reg, prev_next;

    gpioirq_pkg::op_t      op;
    gpioirq_pkg::reg_idx_t idx;
    logic [15:0] wmask;
    logic [15:0] wword;
    logic [15:0] rd_word;
    logic [15:0] rise;
    logic [15:0] fall;
    logic [15:0] edge_ev;
    logic [15:0] lvl_ev;
    logic [15:0] ev;

    // Decode the beat and work out the next register values.
    always_comb begin
        op    = gpioirq_pkg::op_t'(cmd.operation);
        idx   = gpioirq_pkg::reg_idx_t'(cmd.address[3:1]);
        wmask = (cmd.address[0] ? 16'hFF00 : 16'h00FF) & PinMask;
        wword = {cmd.write_data, cmd.write_data};

        rise    = ~prev_reg & cmd.pin_levels;
        fall    = prev_reg & ~cmd.pin_levels;
        edge_ev = (pol_reg & rise) | (~pol_reg & fall);
        lvl_ev  = (pol_reg & cmd.pin_levels) | (~pol_reg & ~cmd.pin_levels);
        ev      = (mode_reg & edge_ev) | (~mode_reg & lvl_ev);

        dir_next    = dir_reg;
        outlvl_next = outlvl_reg;
        status_next = status_reg;
        mode_next   = mode_reg;
        pol_next    = pol_reg;
        irqen_next  = irqen_reg;
        nmien_next  = nmien_reg;
        prev_next   = prev_reg;
        rd_word     = 16'h0000;

        unique case (op)
            gpioirq_pkg::OP_READ: begin
                // Stored bits above the pin count are always zero.
                unique case (idx)
                    gpioirq_pkg::REG_DIRECTION: rd_word = dir_reg;
                    gpioirq_pkg::REG_PIN_LEVEL: rd_word = prev_reg;
                    gpioirq_pkg::REG_STATUS:    rd_word = status_reg;
                    gpioirq_pkg::REG_EV_MODE:   rd_word = mode_reg | ~PinMask;
                    gpioirq_pkg::REG_EV_POL:    rd_word = pol_reg;
                    gpioirq_pkg::REG_IRQ_EN:    rd_word = irqen_reg;
                    gpioirq_pkg::REG_NMI_EN:    rd_word = nmien_reg;
                    gpioirq_pkg::REG_OUT_LEVEL:
                        rd_word = (HAS_OUTPUT_LEVEL_REG != 0) ? outlvl_reg : 16'h0000;
                endcase
            end
            gpioirq_pkg::OP_WRITE: begin
                unique case (idx)
                    gpioirq_pkg::REG_DIRECTION:
                        dir_next = (dir_reg & ~wmask) | (wword & wmask);
                    gpioirq_pkg::REG_PIN_LEVEL:
                        outlvl_next = (outlvl_reg & ~wmask) | (wword & wmask);
                    gpioirq_pkg::REG_STATUS:
                        status_next = status_reg & ~(wword & wmask);
                    gpioirq_pkg::REG_EV_MODE:
                        mode_next = (mode_reg & ~wmask) | (wword & wmask);
                    gpioirq_pkg::REG_EV_POL:
                        pol_next = (pol_reg & ~wmask) | (wword & wmask);
                    gpioirq_pkg::REG_IRQ_EN:
                        irqen_next = (irqen_reg & ~wmask) | (wword & wmask);
                    gpioirq_pkg::REG_NMI_EN:
                        nmien_next = (nmien_reg & ~wmask) | (wword & wmask);
                    gpioirq_pkg::REG_OUT_LEVEL: begin
                        if (HAS_OUTPUT_LEVEL_REG != 0) begin
                            outlvl_next = (outlvl_reg & ~wmask) | (wword & wmask);
                        end
                    end
                endcase
            end
            gpioirq_pkg::OP_SAMPLE: begin
                status_next = status_reg | (ev & PinMask);
                prev_next   = cmd.pin_levels & PinMask;
            end
            default: begin
            end
        endcase
    end

    // Result of the beat reflects the state after it is applied.
    always_comb begin
        result.read_data        = cmd.address[0] ? rd_word[15:8] : rd_word[7:0];
        result.pin_drive        = outlvl_next;
        result.pin_drive_enable = dir_next;
        result.irq_out          = |(status_next & irqen_next);
        result.nmi_out          = |(status_next & nmien_next);
    end

    // State registers advance once per applied beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg    <= 16'h0000;
            outlvl_reg <= 16'h0000;
            status_reg <= 16'h0000;
            mode_reg   <= 16'h0000;
            pol_reg    <= 16'h0000;
            irqen_reg  <= 16'h0000;
            nmien_reg  <= 16'h0000;
            prev_reg   <= 16'h0000;
        end else if (apply) begin
            dir_reg    <= dir_next;
            outlvl_reg <= outlvl_next;
            status_reg <= status_next;
            mode_reg   <= mode_next;
            pol_reg    <= pol_next;
            irqen_reg  <= irqen_next;
            nmien_reg  <= nmien_next;
            prev_reg   <= prev_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A read leaves direction, output level, status, mode, polarity and pin level registers untouched.
    a_read_no_side_effect: assert property (@(posedge aclk) disable iff (!aresetn)
        (apply && cmd.operation == gpioirq_pkg::OP_READ) |=>
            ($stable(dir_reg) && $stable(outlvl_reg) && $stable(status_reg) &&
             $stable(mode_reg) && $stable(pol_reg) && $stable(prev_reg)))
        else $error("register read changed state");

    // A register write can only clear status bits, never set them.
    a_write_only_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (apply && cmd.operation == gpioirq_pkg::OP_WRITE) |=>
            ((status_reg & ~$past(status_reg)) == 16'h0000))
        else $error("register write set a status bit");

    // Bits above the implemented pin count never hold a one.
    a_unimpl_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        ((status_reg | dir_reg | outlvl_reg | prev_reg) & ~PinMask) == 16'h0000)
        else $error("unimplemented pin bit set");
`endif

endmodule

// ===== rtl/gpioirq_out_stage.sv =====
// Result register and output handshake of the GPIO controller.
module gpioirq_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  gpioirq_pkg::result_t result,
    output logic                 can_load,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_read_data,
    output logic [15:0]          m_pin_drive,
    output logic [15:0]          m_pin_drive_enable,
    output logic                 m_irq_out,
    output logic                 m_nmi_out
);

    logic                 valid_reg, valid_next;
    gpioirq_pkg::result_t data_reg;

    // The register takes a new result when it is empty or being drained.
    always_comb begin
        can_load = !valid_reg || m_ready;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_valid            = valid_reg;
    assign m_read_data        = data_reg.read_data;
    assign m_pin_drive        = data_reg.pin_drive;
    assign m_pin_drive_enable = data_reg.pin_drive_enable;
    assign m_irq_out          = data_reg.irq_out;
    assign m_nmi_out          = data_reg.nmi_out;

endmodule

// ===== rtl/gpio_controller_with_event_irq.sv =====
// Top level of the GPIO controller with edge and level event interrupts.
//
// Input channel (s_valid/s_ready): each beat is a register read, a register
// write or a pin sample tick, selected by s_operation. The byte-wide bank has
// sixteen offsets; even offsets address pins 0-7, odd offsets pins 8-15.
// Result channel (m_valid/m_ready): exactly one beat per input beat, in order.
// It carries the byte read (zero for writes and ticks), the pin drive levels
// and enables, and the IRQ and NMI lines, all as they stand after the item.
// A beat accepted on the input channel enters the input register; its result
// is loaded into the result register once that register is empty or draining,
// and m_valid then rises. Throughput is one beat per cycle while m_ready is
// high, set by the single pass from the input register through the register
// bank into the result register.
// Reset (aresetn low, synchronous) clears the bank and valid registers: all pins
// inputs, level mode with low polarity, no status, no enables, both channels empty.
// When the receiver stalls, the result register holds its beat, the input
// register holds one more, and s_ready drops until m_ready returns.
module gpio_controller_with_event_irq #(
    parameter int PIN_COUNT            = gpioirq_pkg::PinCountDefault,
    parameter int HAS_OUTPUT_LEVEL_REG = gpioirq_pkg::HasOutputLevelDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [3:0]  s_address,
    input  logic [7:0]  s_write_data,
    input  logic [15:0] s_pin_levels,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic [15:0] m_pin_drive,
    output logic [15:0] m_pin_drive_enable,
    output logic        m_irq_out,
    output logic        m_nmi_out
);

    gpioirq_pkg::cmd_t    in_reg;
    logic                 in_valid_reg, in_valid_next;
    logic                 can_load;
    logic                 advance;
    logic                 s_accept;
    gpioirq_pkg::result_t result;

    // Input register: refilled when empty or when its beat moves on.
    always_comb begin
        advance  = in_valid_reg && can_load;
        s_ready  = !in_valid_reg || can_load;
        s_accept = s_valid && s_ready;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_reg.operation  <= s_operation;
            in_reg.address    <= s_address;
            in_reg.write_data <= s_write_data;
            in_reg.pin_levels <= s_pin_levels;
        end
    end

    gpioirq_regs #(
        .PIN_COUNT           (PIN_COUNT),
        .HAS_OUTPUT_LEVEL_REG(HAS_OUTPUT_LEVEL_REG)
    ) u_regs (
        .aclk   (aclk),
        .aresetn(aresetn),
        .apply  (advance),
        .cmd    (in_reg),
        .result (result)
    );

    gpioirq_out_stage u_out (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .load              (advance),
        .result            (result),
        .can_load          (can_load),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_read_data       (m_read_data),
        .m_pin_drive       (m_pin_drive),
        .m_pin_drive_enable(m_pin_drive_enable),
        .m_irq_out         (m_irq_out),
        .m_nmi_out         (m_nmi_out)
    );

`ifndef NO_ASSERTIONS
    // A beat waiting in the input register is neither lost nor altered.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !can_load) |=> (in_valid_reg && $stable(in_reg)))
        else $error("input register beat lost while stalled");

    // Writes and sample ticks return a zero read byte.
    a_nonread_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_reg.operation != gpioirq_pkg::OP_READ) |=> (m_read_data == 8'h00))
        else $error("nonzero read byte on a write or tick");

    // A result beat is only ever loaded into an empty or draining register.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !advance)
        else $error("result register overwritten while stalled");
`endif

endmodule
